FILE: hdl/srad_pkg.sv
// Package for the smoke ratio alarm detector: shared types, constants and helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none
package srad_pkg;

    localparam int AVG_MAX = 16;
    localparam int CNT_W = 5;
    localparam int SUM_W = 36;
    localparam int DVD_W = 60;
    localparam int DVS_W = 32;
    localparam int STEP_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] PLAUS_LOW = 32'd100;
    localparam logic [31:0] PLAUS_HIGH = 32'd200000000;
    localparam logic [31:0] BASE_DEFAULT = 32'd335544;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SMOOTHING = 3'd0;
    localparam logic [2:0] REG_WARMUP = 3'd1;
    localparam logic [2:0] REG_GUARD = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_PERSIST_ON = 3'd4;
    localparam logic [2:0] REG_PERSIST_OFF = 3'd5;
    localparam logic [2:0] REG_FLAGS = 3'd6;
    localparam logic [2:0] REG_GAIN = 3'd7;

    localparam int MODE_TRANSMISSIVE = 0;
    localparam int MODE_LOCK = 1;

    typedef struct packed {
        logic [15:0] smoothing_weight;
        logic [7:0]  warmup_count;
        logic [31:0] adapt_guard;
        logic [31:0] score_threshold;
        logic [7:0]  persist_on;
        logic [7:0]  persist_off;
        logic [1:0]  mode_flags;
        logic [15:0] gain_correction;
    } cfg_t;

    // One finished averaging group handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] blue_sum;
        logic [SUM_W-1:0] ir_sum;
        logic [CNT_W-1:0] count;
    } grp_t;

    function automatic logic plausible(input logic [31:0] v);
        return (v > PLAUS_LOW) && (v < PLAUS_HIGH);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/srad_front.sv
// Front end: halfword order decision and group accumulation.
// Depends on srad_pkg; pushes finished groups into srad_queue.
`default_nettype none
module srad_front import srad_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_word0,
    input  wire logic [15:0] s_word1,
    input  wire logic [15:0] s_word2,
    input  wire logic [15:0] s_word3,
    input  wire logic        s_group_end,
    input  wire logic        q_full,
    output logic             q_push,
    output grp_t             q_data
);

    logic             order_decided_reg;
    logic             swap_halves_reg;
    logic [SUM_W-1:0] blue_sum_reg;
    logic [SUM_W-1:0] ir_sum_reg;
    logic [CNT_W-1:0] count_reg;

    logic             accept;
    logic             swap_now;
    logic [31:0]      blue_val;
    logic [31:0]      ir_val;
    logic [SUM_W-1:0] blue_next;
    logic [SUM_W-1:0] ir_next;
    logic [CNT_W-1:0] count_next;
    logic             group_done;
    logic             ba_ok;
    logic             ab_ok;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;

    always_comb begin
        ba_ok = plausible({s_word1, s_word0}) && plausible({s_word3, s_word2});
        ab_ok = plausible({s_word0, s_word1}) && plausible({s_word2, s_word3});
        swap_now = order_decided_reg ? swap_halves_reg : (ba_ok || !ab_ok);
        blue_val = swap_now ? {s_word1, s_word0} : {s_word0, s_word1};
        ir_val = swap_now ? {s_word3, s_word2} : {s_word2, s_word3};
        blue_next = blue_sum_reg + {{(SUM_W-32){1'b0}}, blue_val};
        ir_next = ir_sum_reg + {{(SUM_W-32){1'b0}}, ir_val};
        count_next = count_reg + CNT_W'(1);
        group_done = s_group_end || (count_next == CNT_W'(AVG_MAX));
    end

    assign q_push = accept && group_done;
    assign q_data = '{blue_sum: blue_next, ir_sum: ir_next, count: count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_decided_reg <= 1'b0;
            swap_halves_reg <= 1'b1;
            blue_sum_reg <= '0;
            ir_sum_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            order_decided_reg <= 1'b1;
            swap_halves_reg <= swap_now;
            if (group_done) begin
                blue_sum_reg <= '0;
                ir_sum_reg <= '0;
                count_reg <= '0;
            end else begin
                blue_sum_reg <= blue_next;
                ir_sum_reg <= ir_next;
                count_reg <= count_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/srad_queue.sv
// Two-entry queue of finished groups between the front and the back.
// Depends on srad_pkg for the group type.
`default_nettype none
module srad_queue import srad_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  grp_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output grp_t      pop_data
);

    grp_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full = (fill_reg == 2'(QUEUE_DEPTH));
    assign empty = (fill_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

endmodule
`default_nettype wire

FILE: hdl/srad_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on srad_pkg for widths; used by srad_back.
`default_nettype none
module srad_div import srad_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    input  wire logic [STEP_W-1:0] steps,
    output logic                   done,
    output logic [DVD_W-1:0]       quotient
);

    // The dividend must be left-aligned; after the given number of steps
    // the quotient sits in the low bits and the vacated high bits are zero.
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits = rem_sh >= {1'b0, dvs_reg};
    assign done = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/srad_back.sv
// Back end: averages, ratio, baseline tracking, score and alarm hysteresis.
// Depends on srad_pkg and srad_div; pops groups from srad_queue.
`default_nettype none
module srad_back import srad_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_t             cfg,
    input  wire logic        q_empty,
    input  grp_t             q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_avg_blue,
    output logic [31:0]      m_avg_ir,
    output logic [4:0]       m_packets_averaged,
    output logic [31:0]      m_cur_ratio,
    output logic [31:0]      m_baseline_out,
    output logic signed [32:0] m_score_out,
    output logic             m_baseline_updated,
    output logic             m_alarm_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_B, S_DIV_I, S_MUL, S_DIV_R, S_EMA_MUL, S_UPDATE, S_SCORE
    } state_t;

    state_t           state_reg;
    grp_t             grp_reg;
    logic [31:0]      avg_b_reg;
    logic [31:0]      avg_ir_reg;
    logic [47:0]      prod_reg;
    logic [31:0]      ratio_reg;
    logic [48:0]      pa_reg;
    logic [48:0]      pb_reg;
    logic [7:0]       warmup_seen_reg;
    logic             ready_flag_reg;
    logic [31:0]      baseline_reg;
    logic             updated_reg;
    logic [7:0]       over_reg;
    logic [7:0]       under_reg;
    logic             alarm_reg;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [STEP_W-1:0] div_steps;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    logic [48:0]      ema_sum;
    logic [31:0]      ema_val;
    logic [7:0]       seen_inc;
    logic [31:0]      diff;
    logic [31:0]      base_used;
    logic signed [33:0] score_wide;
    logic             on_now;
    logic [7:0]       over_next;
    logic [7:0]       under_next;
    logic             alarm_next;
    logic             out_free;

    srad_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !m_valid || m_ready;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb begin
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        div_steps = STEP_W'(SUM_W);
        case (state_reg)
            S_IDLE: begin
                div_start = !q_empty;
                div_dividend = {q_data.blue_sum, {(DVD_W-SUM_W){1'b0}}};
                div_divisor = DVS_W'(q_data.count);
            end
            S_DIV_B: begin
                div_start = div_done;
                div_dividend = {grp_reg.ir_sum, {(DVD_W-SUM_W){1'b0}}};
                div_divisor = DVS_W'(grp_reg.count);
            end
            S_MUL: begin
                div_start = (avg_ir_reg != '0);
                div_dividend = {prod_reg, 12'b0};
                div_divisor = avg_ir_reg;
                div_steps = STEP_W'(DVD_W);
            end
            default: ;
        endcase
    end

    always_comb begin
        ema_sum = pa_reg + pb_reg;
        ema_val = ema_sum[47:16];
        seen_inc = warmup_seen_reg + 8'd1;
        diff = (ratio_reg > baseline_reg) ? ratio_reg - baseline_reg
                                          : baseline_reg - ratio_reg;
        base_used = (baseline_reg != '0) ? baseline_reg : BASE_DEFAULT;
        score_wide = $signed({2'b0, ratio_reg}) - $signed({2'b0, base_used});
        if (cfg.mode_flags[MODE_TRANSMISSIVE]) begin
            score_wide = -score_wide;
        end
        on_now = ready_flag_reg && (score_wide > $signed({2'b0, cfg.score_threshold}));
        if (on_now) begin
            over_next = (over_reg == 8'hFF) ? over_reg : over_reg + 8'd1;
            under_next = '0;
        end else begin
            under_next = (under_reg == 8'hFF) ? under_reg : under_reg + 8'd1;
            over_next = '0;
        end
        alarm_next = alarm_reg;
        if (!alarm_next && over_next >= cfg.persist_on) begin
            alarm_next = 1'b1;
        end
        if (alarm_next && under_next >= cfg.persist_off) begin
            alarm_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            warmup_seen_reg <= '0;
            ready_flag_reg <= 1'b0;
            baseline_reg <= '0;
            over_reg <= '0;
            under_reg <= '0;
            alarm_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if ((state_reg == S_SCORE) && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        grp_reg <= q_data;
                        state_reg <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (div_done) begin
                        avg_b_reg <= div_q[31:0];
                        state_reg <= S_DIV_I;
                    end
                end
                S_DIV_I: begin
                    if (div_done) begin
                        avg_ir_reg <= div_q[31:0];
                        prod_reg <= avg_b_reg * cfg.gain_correction;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (avg_ir_reg == '0) begin
                        ratio_reg <= '0;
                        state_reg <= S_EMA_MUL;
                    end else begin
                        state_reg <= S_DIV_R;
                    end
                end
                S_DIV_R: begin
                    if (div_done) begin
                        ratio_reg <= (div_q[DVD_W-1:32] != '0) ? '1 : div_q[31:0];
                        state_reg <= S_EMA_MUL;
                    end
                end
                S_EMA_MUL: begin
                    pa_reg <= (17'h10000 - {1'b0, cfg.smoothing_weight}) * baseline_reg;
                    pb_reg <= {1'b0, cfg.smoothing_weight} * ratio_reg;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (warmup_seen_reg < cfg.warmup_count) begin
                        warmup_seen_reg <= seen_inc;
                        baseline_reg <= (seen_inc == 8'd1) ? ratio_reg : ema_val;
                        updated_reg <= 1'b1;
                        if (seen_inc >= cfg.warmup_count) begin
                            ready_flag_reg <= 1'b1;
                        end
                    end else if (!cfg.mode_flags[MODE_LOCK] && diff < cfg.adapt_guard) begin
                        baseline_reg <= ema_val;
                        updated_reg <= 1'b1;
                    end else begin
                        updated_reg <= 1'b0;
                    end
                    state_reg <= S_SCORE;
                end
                S_SCORE: begin
                    if (out_free) begin
                        over_reg <= over_next;
                        under_reg <= under_next;
                        alarm_reg <= alarm_next;
                        m_avg_blue <= avg_b_reg;
                        m_avg_ir <= avg_ir_reg;
                        m_packets_averaged <= grp_reg.count;
                        m_cur_ratio <= ratio_reg;
                        m_baseline_out <= base_used;
                        m_score_out <= score_wide[32:0];
                        m_baseline_updated <= updated_reg;
                        m_alarm_out <= alarm_next;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/smoke_ratio_alarm_detector.sv
// Top level of the smoke ratio alarm detector: configuration registers and wiring.
// Depends on srad_pkg, srad_front, srad_queue and srad_back.
`default_nettype none
// Packets are taken one per cycle while the two-entry group queue has room;
// only a packet that ends a group (group-end flag or the 16th packet) occupies
// a queue entry. The back end processes each group on the shared divider,
// one quotient bit per cycle: 36 steps for each of the two averages and 60
// for the ratio, plus the gain and baseline multiplies. A result is held in
// the output register until taken while the next group is already computed.
module smoke_ratio_alarm_detector import srad_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_word0,
    input  wire logic [15:0] s_word1,
    input  wire logic [15:0] s_word2,
    input  wire logic [15:0] s_word3,
    input  wire logic        s_group_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_avg_blue,
    output logic [31:0]      m_avg_ir,
    output logic [4:0]       m_packets_averaged,
    output logic [31:0]      m_cur_ratio,
    output logic [31:0]      m_baseline_out,
    output logic signed [32:0] m_score_out,
    output logic             m_baseline_updated,
    output logic             m_alarm_out
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    grp_t q_in;
    grp_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoothing_weight <= 16'd655;
            cfg_reg.warmup_count <= 8'd32;
            cfg_reg.adapt_guard <= 32'd838861;
            cfg_reg.score_threshold <= 32'd167772;
            cfg_reg.persist_on <= 8'd3;
            cfg_reg.persist_off <= 8'd6;
            cfg_reg.mode_flags <= 2'd0;
            cfg_reg.gain_correction <= 16'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SMOOTHING:   cfg_reg.smoothing_weight <= cfg_data[15:0];
                REG_WARMUP:      cfg_reg.warmup_count <= cfg_data[7:0];
                REG_GUARD:       cfg_reg.adapt_guard <= cfg_data;
                REG_THRESHOLD:   cfg_reg.score_threshold <= cfg_data;
                REG_PERSIST_ON:  cfg_reg.persist_on <= cfg_data[7:0];
                REG_PERSIST_OFF: cfg_reg.persist_off <= cfg_data[7:0];
                REG_FLAGS:       cfg_reg.mode_flags <= cfg_data[1:0];
                REG_GAIN:        cfg_reg.gain_correction <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    srad_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word0     (s_word0),
        .s_word1     (s_word1),
        .s_word2     (s_word2),
        .s_word3     (s_word3),
        .s_group_end (s_group_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    srad_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    srad_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_empty            (q_empty),
        .q_data             (q_out),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_avg_blue         (m_avg_blue),
        .m_avg_ir           (m_avg_ir),
        .m_packets_averaged (m_packets_averaged),
        .m_cur_ratio        (m_cur_ratio),
        .m_baseline_out     (m_baseline_out),
        .m_score_out        (m_score_out),
        .m_baseline_updated (m_baseline_updated),
        .m_alarm_out        (m_alarm_out)
    );

endmodule
`default_nettype wire
